/* sv/fsup_pkg.sv */
// shared constants, types and helper functions for the fault supervisor
package fsup_pkg;

  // tick counter width and saturation value
  localparam int unsigned TICK_COUNT_BITS = 16;
  localparam logic [TICK_COUNT_BITS-1:0] TICK_MAX = {TICK_COUNT_BITS{1'b1}};

  // field widths
  localparam int unsigned DIST_W     = 8;
  localparam int unsigned TEMP_W     = 11;
  localparam int unsigned ANGLE_W    = 12;
  localparam int unsigned TILT_W     = 11;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned CODE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // range sensor clamp
  localparam logic [DIST_W-1:0] MAX_RANGE_CM = DIST_W'(200);

  // fault codes
  localparam logic [CODE_W-1:0] FAULT_NONE     = 3'd0;
  localparam logic [CODE_W-1:0] FAULT_DISTANCE = 3'd1;
  localparam logic [CODE_W-1:0] FAULT_TILT     = 3'd2;
  localparam logic [CODE_W-1:0] FAULT_TEMP     = 3'd3;
  localparam logic [CODE_W-1:0] FAULT_WATCHDOG = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OBS_FAULT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBS_WARN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_WARN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_FLT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OBS_HOLD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG  = 3'd6;

  // configuration reset values
  localparam logic [DIST_W-1:0]        RST_OBS_FAULT = 8'd15;
  localparam logic [DIST_W-1:0]        RST_OBS_WARN  = 8'd30;
  localparam logic signed [TEMP_W-1:0] RST_TEMP_WARN = 11'sd350;
  localparam logic signed [TEMP_W-1:0] RST_TEMP_FLT  = 11'sd400;
  localparam logic [TILT_W-1:0]        RST_TILT_LIM  = 11'd300;
  localparam logic [HOLD_W-1:0]        RST_OBS_HOLD  = 16'd1000;
  localparam logic [HOLD_W-1:0]        RST_WATCHDOG  = 16'd500;

  // configuration register set
  typedef struct packed {
    logic [DIST_W-1:0]        obstacle_fault_cm;
    logic [DIST_W-1:0]        obstacle_warn_cm;
    logic signed [TEMP_W-1:0] temp_warn_tenths;
    logic signed [TEMP_W-1:0] temp_fault_tenths;
    logic [TILT_W-1:0]        tilt_limit_tenths;
    logic [HOLD_W-1:0]        obstacle_hold_ticks;
    logic [HOLD_W-1:0]        watchdog_ticks;
  } cfg_t;

  // one input item
  typedef struct packed {
    logic                      link_up;
    logic                      button_pressed;
    logic                      heartbeat;
    logic [DIST_W-1:0]         distance_cm;
    logic                      temp_valid;
    logic signed [TEMP_W-1:0]  temperature_tenths;
    logic signed [ANGLE_W-1:0] pitch_tenths;
    logic signed [ANGLE_W-1:0] roll_tenths;
  } item_t;

  // one result item
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              fault_active;
    logic [CODE_W-1:0] fault_code;
    logic              warn_obstacle;
    logic              warn_temp;
    logic              alert_raised;
    logic              stop_motors;
  } res_t;

  // saturating tick counter increment
  function automatic logic [TICK_COUNT_BITS-1:0] sat_inc(logic [TICK_COUNT_BITS-1:0] v);
    sat_inc = (v == TICK_MAX) ? v : v + TICK_COUNT_BITS'(1);
  endfunction

endpackage

/* sv/fsup_if.sv */
// valid/ready channel interfaces for items, results and configuration writes

// input item channel
interface fsup_in_if;
  logic                               valid;
  logic                               ready;
  logic                               link_up;
  logic                               button_pressed;
  logic                               heartbeat;
  logic [fsup_pkg::DIST_W-1:0]        distance_cm;
  logic                               temp_valid;
  logic signed [fsup_pkg::TEMP_W-1:0] temperature_tenths;
  logic signed [fsup_pkg::ANGLE_W-1:0] pitch_tenths;
  logic signed [fsup_pkg::ANGLE_W-1:0] roll_tenths;

  modport source (
    output valid, link_up, button_pressed, heartbeat, distance_cm, temp_valid,
           temperature_tenths, pitch_tenths, roll_tenths,
    input  ready
  );
  modport sink (
    input  valid, link_up, button_pressed, heartbeat, distance_cm, temp_valid,
           temperature_tenths, pitch_tenths, roll_tenths,
    output ready
  );
endinterface

// result channel
interface fsup_res_if;
  logic                        valid;
  logic                        ready;
  logic [fsup_pkg::MODE_W-1:0] mode;
  logic                        fault_active;
  logic [fsup_pkg::CODE_W-1:0] fault_code;
  logic                        warn_obstacle;
  logic                        warn_temp;
  logic                        alert_raised;
  logic                        stop_motors;

  modport source (
    output valid, mode, fault_active, fault_code, warn_obstacle, warn_temp,
           alert_raised, stop_motors,
    input  ready
  );
  modport sink (
    input  valid, mode, fault_active, fault_code, warn_obstacle, warn_temp,
           alert_raised, stop_motors,
    output ready
  );
endinterface

// configuration write channel
interface fsup_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fsup_pkg::CFG_IDX_W-1:0]  index;
  logic [fsup_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/fsup_cfg_regs.sv */
// configuration register file with reset defaults
module fsup_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  fsup_cfg_if.sink         cfg_i,
  output fsup_pkg::cfg_t   cfg_o
);

  fsup_pkg::cfg_t cfg_q;
  logic           wr_en;

  // writes are always taken
  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid & cfg_i.ready;
  assign cfg_o       = cfg_q;

  // register writes by index, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.obstacle_fault_cm   <= fsup_pkg::RST_OBS_FAULT;
      cfg_q.obstacle_warn_cm    <= fsup_pkg::RST_OBS_WARN;
      cfg_q.temp_warn_tenths    <= fsup_pkg::RST_TEMP_WARN;
      cfg_q.temp_fault_tenths   <= fsup_pkg::RST_TEMP_FLT;
      cfg_q.tilt_limit_tenths   <= fsup_pkg::RST_TILT_LIM;
      cfg_q.obstacle_hold_ticks <= fsup_pkg::RST_OBS_HOLD;
      cfg_q.watchdog_ticks      <= fsup_pkg::RST_WATCHDOG;
    end else if (wr_en) begin
      case (cfg_i.index)
        fsup_pkg::CFG_OBS_FAULT: cfg_q.obstacle_fault_cm <= cfg_i.data[fsup_pkg::DIST_W-1:0];
        fsup_pkg::CFG_OBS_WARN:  cfg_q.obstacle_warn_cm  <= cfg_i.data[fsup_pkg::DIST_W-1:0];
        fsup_pkg::CFG_TEMP_WARN: cfg_q.temp_warn_tenths  <= $signed(cfg_i.data[fsup_pkg::TEMP_W-1:0]);
        fsup_pkg::CFG_TEMP_FLT:  cfg_q.temp_fault_tenths <= $signed(cfg_i.data[fsup_pkg::TEMP_W-1:0]);
        fsup_pkg::CFG_TILT_LIM:  cfg_q.tilt_limit_tenths <= cfg_i.data[fsup_pkg::TILT_W-1:0];
        fsup_pkg::CFG_OBS_HOLD:  cfg_q.obstacle_hold_ticks <= cfg_i.data[fsup_pkg::HOLD_W-1:0];
        fsup_pkg::CFG_WATCHDOG:  cfg_q.watchdog_ticks    <= cfg_i.data[fsup_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/fsup_supervisor.sv */
// supervisor state machine, fault checks and tick timers for one item
module fsup_supervisor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  fsup_pkg::item_t   item_i,
  input  fsup_pkg::cfg_t    cfg_i,
  output fsup_pkg::res_t    res_o
);

  typedef enum logic [fsup_pkg::MODE_W-1:0] {
    MODE_IDLE      = 3'd0,
    MODE_ONLINE    = 3'd1,
    MODE_MANUAL    = 3'd2,
    MODE_FAULT     = 3'd3,
    MODE_RESET_REQ = 3'd4
  } mode_e;

  localparam int unsigned CMP_W =
    (fsup_pkg::TICK_COUNT_BITS > fsup_pkg::HOLD_W) ? fsup_pkg::TICK_COUNT_BITS : fsup_pkg::HOLD_W;

  mode_e                               mode_q, mode_d;
  logic                                flag_q, flag_d;
  logic [fsup_pkg::CODE_W-1:0]         code_q, code_d;
  logic                                timing_q, timing_d;
  logic [fsup_pkg::TICK_COUNT_BITS-1:0] obs_age_q, obs_age_d;
  logic [fsup_pkg::TICK_COUNT_BITS-1:0] hb_age_q, hb_age_d;

  logic [fsup_pkg::DIST_W-1:0]  range_cm;
  logic [fsup_pkg::ANGLE_W-1:0] pitch_abs;
  logic [fsup_pkg::ANGLE_W-1:0] roll_abs;
  logic [fsup_pkg::ANGLE_W-1:0] tilt_lim;
  logic                         checks;
  logic                         warn_obs;
  logic                         warn_tmp;
  logic                         alert;

  // magnitude of a signed angle, full negative value fits unsigned
  function automatic logic [fsup_pkg::ANGLE_W-1:0] mag(logic signed [fsup_pkg::ANGLE_W-1:0] v);
    mag = v[fsup_pkg::ANGLE_W-1] ? (~v + fsup_pkg::ANGLE_W'(1)) : v;
  endfunction

  // operand conditioning
  always_comb begin
    range_cm  = (item_i.distance_cm > fsup_pkg::MAX_RANGE_CM) ? fsup_pkg::MAX_RANGE_CM
                                                              : item_i.distance_cm;
    pitch_abs = mag(item_i.pitch_tenths);
    roll_abs  = mag(item_i.roll_tenths);
    tilt_lim  = fsup_pkg::ANGLE_W'(cfg_i.tilt_limit_tenths);
  end

  // timers, mode transition, then checks in manual with a valid temperature
  always_comb begin
    mode_d    = mode_q;
    flag_d    = flag_q;
    code_d    = code_q;
    timing_d  = timing_q;
    hb_age_d  = item_i.heartbeat ? '0 : fsup_pkg::sat_inc(hb_age_q);
    obs_age_d = timing_q ? fsup_pkg::sat_inc(obs_age_q) : obs_age_q;
    alert     = 1'b0;

    case (mode_q)
      MODE_IDLE:      if (item_i.link_up) mode_d = MODE_ONLINE;
      MODE_ONLINE:    if (item_i.button_pressed) mode_d = MODE_MANUAL;
      MODE_MANUAL:    if (flag_q) mode_d = MODE_FAULT;
      MODE_FAULT:     if (item_i.button_pressed) mode_d = MODE_RESET_REQ;
      MODE_RESET_REQ: begin
        if (item_i.button_pressed) begin
          flag_d = 1'b0;
          mode_d = MODE_IDLE;
        end
      end
      default: ;
    endcase

    checks   = (mode_d == MODE_MANUAL) && item_i.temp_valid;
    warn_obs = checks && (range_cm > cfg_i.obstacle_fault_cm)
                      && (range_cm < cfg_i.obstacle_warn_cm);
    warn_tmp = checks && (item_i.temperature_tenths > cfg_i.temp_warn_tenths)
                      && (item_i.temperature_tenths < cfg_i.temp_fault_tenths);

    if (checks) begin
      // obstacle persistence, later faults override the code
      if (range_cm <= cfg_i.obstacle_fault_cm) begin
        if (!timing_q) begin
          timing_d  = 1'b1;
          obs_age_d = '0;
        end
        if (CMP_W'(obs_age_d) > CMP_W'(cfg_i.obstacle_hold_ticks)) begin
          alert  = 1'b1;
          code_d = fsup_pkg::FAULT_DISTANCE;
        end
      end else begin
        timing_d  = 1'b0;
        obs_age_d = '0;
      end
      if ((pitch_abs > tilt_lim) || (roll_abs > tilt_lim)) begin
        alert  = 1'b1;
        code_d = fsup_pkg::FAULT_TILT;
      end
      if (item_i.temperature_tenths >= cfg_i.temp_fault_tenths) begin
        alert  = 1'b1;
        code_d = fsup_pkg::FAULT_TEMP;
      end
      if (CMP_W'(hb_age_d) > CMP_W'(cfg_i.watchdog_ticks)) begin
        alert  = 1'b1;
        code_d = fsup_pkg::FAULT_WATCHDOG;
      end
      if (alert) flag_d = 1'b1;
    end
  end

  // result for the item being retired
  always_comb begin
    res_o.mode          = mode_d;
    res_o.fault_active  = flag_d;
    res_o.fault_code    = code_d;
    res_o.warn_obstacle = warn_obs;
    res_o.warn_temp     = warn_tmp;
    res_o.alert_raised  = alert;
    res_o.stop_motors   = (mode_d == MODE_FAULT);
  end

  // supervisor state, updated once per retired item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      flag_q    <= 1'b0;
      code_q    <= fsup_pkg::FAULT_NONE;
      timing_q  <= 1'b0;
      obs_age_q <= '0;
      hb_age_q  <= '0;
    end else if (advance_i) begin
      mode_q    <= mode_d;
      flag_q    <= flag_d;
      code_q    <= code_d;
      timing_q  <= timing_d;
      obs_age_q <= obs_age_d;
      hb_age_q  <= hb_age_d;
    end
  end

  // fault mode is only reachable with the fault latched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_FAULT) |-> flag_q)
    else $error("fault mode without latched fault");

  // a latched fault always carries a code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    flag_q |-> (code_q != fsup_pkg::FAULT_NONE))
    else $error("fault latched with no code");

  // obstacle age only counts while the timer runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !timing_q |-> (obs_age_q == '0))
    else $error("obstacle age nonzero with timer stopped");

  // state only moves when an item is retired
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> ($stable(mode_q) && $stable(hb_age_q) && $stable(code_q)))
    else $error("supervisor state changed without an item");

endmodule

/* sv/fault_supervisor_fsm_top.sv */
// fault supervisor top level: input register, supervisor step and result register
// Usage:
//   in_i carries one tick item per transaction (link, button, heartbeat, distance,
//   temperature, pitch, roll); out_o returns exactly one result per item, in order:
//   mode, latched fault flag and code, the two warnings, alert and motor stop.
//   cfg_i writes one of seven threshold registers per transaction; it is always
//   ready and should only be written while no item is in flight.
// Flow: an accepted item waits in the input register until the result register is
//   free or draining, is then retired into it, and its result is offered on out_o.
// Throughput: one item per cycle unless out_o stalls; the supervisor state feeding
//   back from one item to the next is a single register level through shallow
//   compare logic.
// Stall: when out_o is held off the result register keeps its transaction and the
//   input register takes one more item, then in_i.ready drops until the result drains.
// Reset: rst_ni clears the mode to idle, the fault flag, fault code, obstacle timer
//   and heartbeat age, empties both registers and loads the threshold defaults.
module fault_supervisor_fsm_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  fsup_in_if.sink      in_i,
  fsup_res_if.source   out_o,
  fsup_cfg_if.sink     cfg_i
);

  fsup_pkg::cfg_t  cfg;
  fsup_pkg::item_t item_q;
  fsup_pkg::res_t  res;
  fsup_pkg::res_t  res_q;
  logic            in_vld_q;
  logic            out_vld_q;
  logic            advance;
  logic            in_take;

  // retire the held item when the result register is free or draining
  assign advance    = in_vld_q & (~out_vld_q | out_o.ready);
  assign in_i.ready = ~in_vld_q | advance;
  assign in_take    = in_i.valid & in_i.ready;

  fsup_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  fsup_supervisor u_sup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // valid flags for both register stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) in_vld_q <= in_i.valid;
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.link_up            <= in_i.link_up;
      item_q.button_pressed     <= in_i.button_pressed;
      item_q.heartbeat          <= in_i.heartbeat;
      item_q.distance_cm        <= in_i.distance_cm;
      item_q.temp_valid         <= in_i.temp_valid;
      item_q.temperature_tenths <= in_i.temperature_tenths;
      item_q.pitch_tenths       <= in_i.pitch_tenths;
      item_q.roll_tenths        <= in_i.roll_tenths;
    end
    if (advance) res_q <= res;
  end

  // result channel
  assign out_o.valid         = out_vld_q;
  assign out_o.mode          = res_q.mode;
  assign out_o.fault_active  = res_q.fault_active;
  assign out_o.fault_code    = res_q.fault_code;
  assign out_o.warn_obstacle = res_q.warn_obstacle;
  assign out_o.warn_temp     = res_q.warn_temp;
  assign out_o.alert_raised  = res_q.alert_raised;
  assign out_o.stop_motors   = res_q.stop_motors;

endmodule

/* tb/fault_supervisor_fsm_top_tb.sv */
// self-checking testbench for the fault supervisor top level with a built-in supervisor predictor
module fault_supervisor_fsm_top_tb;

  // supervisor modes as seen on the mode output
  typedef enum logic [fsup_pkg::MODE_W-1:0] {
    MODE_IDLE      = 3'd0,
    MODE_ONLINE    = 3'd1,
    MODE_MANUAL    = 3'd2,
    MODE_FAULT     = 3'd3,
    MODE_RESET_REQ = 3'd4
  } sup_mode_e;

  logic clk_i;
  logic rst_ni;

  fsup_in_if  tick_ch ();
  fsup_res_if status_ch ();
  fsup_cfg_if thr_ch ();

  fault_supervisor_fsm_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_ch),
    .out_o  (status_ch),
    .cfg_i  (thr_ch)
  );

  // predicted supervisor state and threshold copy
  sup_mode_e                            sup_mode;
  logic                                 flt_latched;
  logic [fsup_pkg::CODE_W-1:0]          flt_code;
  logic                                 obs_running;
  logic [fsup_pkg::TICK_COUNT_BITS-1:0] obs_age;
  logic [fsup_pkg::TICK_COUNT_BITS-1:0] hb_age;
  fsup_pkg::cfg_t                       thr;

  fsup_pkg::item_t tick_queue[$];
  fsup_pkg::res_t  status_expected[$];
  int    ticks_queued;
  int    ticks_accepted;
  int    fail_count;
  logic  tick_taken;
  int    send_gap, send_calm, stall_left, sink_calm;
  int    hb_drought, obs_run;

  // clock
  always #1 clk_i = ~clk_i;

  // saturating tick age
  function automatic logic [fsup_pkg::TICK_COUNT_BITS-1:0] age_up(
      logic [fsup_pkg::TICK_COUNT_BITS-1:0] v);
    return (v == fsup_pkg::TICK_MAX) ? v : v + fsup_pkg::TICK_COUNT_BITS'(1);
  endfunction

  // threshold register write into the local copy
  function automatic void apply_threshold(logic [fsup_pkg::CFG_IDX_W-1:0] idx,
                                          logic [fsup_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      fsup_pkg::CFG_OBS_FAULT: thr.obstacle_fault_cm = data[fsup_pkg::DIST_W-1:0];
      fsup_pkg::CFG_OBS_WARN:  thr.obstacle_warn_cm = data[fsup_pkg::DIST_W-1:0];
      fsup_pkg::CFG_TEMP_WARN: thr.temp_warn_tenths = data[fsup_pkg::TEMP_W-1:0];
      fsup_pkg::CFG_TEMP_FLT:  thr.temp_fault_tenths = data[fsup_pkg::TEMP_W-1:0];
      fsup_pkg::CFG_TILT_LIM:  thr.tilt_limit_tenths = data[fsup_pkg::TILT_W-1:0];
      fsup_pkg::CFG_OBS_HOLD:  thr.obstacle_hold_ticks = data[fsup_pkg::HOLD_W-1:0];
      fsup_pkg::CFG_WATCHDOG:  thr.watchdog_ticks = data[fsup_pkg::HOLD_W-1:0];
      default: ;
    endcase
  endfunction

  // one supervisor tick: ages, mode transition, then checks in manual with a valid temperature
  function automatic fsup_pkg::res_t supervise_tick(fsup_pkg::item_t t);
    fsup_pkg::res_t              r;
    logic [fsup_pkg::DIST_W-1:0] range_cm;
    int                          deg, pch, rll, lim, t_warn, t_flt;
    logic                        alert;
    range_cm = (t.distance_cm > fsup_pkg::MAX_RANGE_CM) ? fsup_pkg::MAX_RANGE_CM
                                                        : t.distance_cm;
    deg      = int'($signed(t.temperature_tenths));
    pch      = int'($signed(t.pitch_tenths));
    rll      = int'($signed(t.roll_tenths));
    lim      = int'(thr.tilt_limit_tenths);
    t_warn   = int'($signed(thr.temp_warn_tenths));
    t_flt    = int'($signed(thr.temp_fault_tenths));
    if (pch < 0) pch = -pch;
    if (rll < 0) rll = -rll;
    r     = '0;
    alert = 1'b0;

    hb_age = t.heartbeat ? '0 : age_up(hb_age);
    if (obs_running) obs_age = age_up(obs_age);

    case (sup_mode)
      MODE_IDLE:      if (t.link_up) sup_mode = MODE_ONLINE;
      MODE_ONLINE:    if (t.button_pressed) sup_mode = MODE_MANUAL;
      MODE_MANUAL:    if (flt_latched) sup_mode = MODE_FAULT;
      MODE_FAULT:     if (t.button_pressed) sup_mode = MODE_RESET_REQ;
      MODE_RESET_REQ: begin
        if (t.button_pressed) begin
          flt_latched = 1'b0;
          sup_mode    = MODE_IDLE;
        end
      end
      default: ;
    endcase

    if (sup_mode == MODE_MANUAL && t.temp_valid) begin
      r.warn_obstacle = range_cm > thr.obstacle_fault_cm && range_cm < thr.obstacle_warn_cm;
      r.warn_temp     = deg > t_warn && deg < t_flt;
      // obstacle persistence timer, later faults override the code
      if (range_cm <= thr.obstacle_fault_cm) begin
        if (!obs_running) begin
          obs_running = 1'b1;
          obs_age     = '0;
        end
        if (obs_age > thr.obstacle_hold_ticks) begin
          alert    = 1'b1;
          flt_code = fsup_pkg::FAULT_DISTANCE;
        end
      end else begin
        obs_running = 1'b0;
        obs_age     = '0;
      end
      if (pch > lim || rll > lim) begin
        alert    = 1'b1;
        flt_code = fsup_pkg::FAULT_TILT;
      end
      if (deg >= t_flt) begin
        alert    = 1'b1;
        flt_code = fsup_pkg::FAULT_TEMP;
      end
      if (hb_age > thr.watchdog_ticks) begin
        alert    = 1'b1;
        flt_code = fsup_pkg::FAULT_WATCHDOG;
      end
      if (alert) flt_latched = 1'b1;
    end

    r.mode         = sup_mode;
    r.fault_active = flt_latched;
    r.fault_code   = flt_code;
    r.alert_raised = alert;
    r.stop_motors  = (sup_mode == MODE_FAULT);
    return r;
  endfunction

  // field by field comparison of one result transaction
  function automatic void check_status(fsup_pkg::res_t exp, fsup_pkg::res_t got);
    if (got.mode !== exp.mode) begin
      $error("mode: expected %0d, actual %0d", exp.mode, got.mode);
      fail_count++;
    end
    if (got.fault_active !== exp.fault_active) begin
      $error("fault_active: expected %0d, actual %0d", exp.fault_active, got.fault_active);
      fail_count++;
    end
    if (got.fault_code !== exp.fault_code) begin
      $error("fault_code: expected %0d, actual %0d", exp.fault_code, got.fault_code);
      fail_count++;
    end
    if (got.warn_obstacle !== exp.warn_obstacle) begin
      $error("warn_obstacle: expected %0d, actual %0d", exp.warn_obstacle, got.warn_obstacle);
      fail_count++;
    end
    if (got.warn_temp !== exp.warn_temp) begin
      $error("warn_temp: expected %0d, actual %0d", exp.warn_temp, got.warn_temp);
      fail_count++;
    end
    if (got.alert_raised !== exp.alert_raised) begin
      $error("alert_raised: expected %0d, actual %0d", exp.alert_raised, got.alert_raised);
      fail_count++;
    end
    if (got.stop_motors !== exp.stop_motors) begin
      $error("stop_motors: expected %0d, actual %0d", exp.stop_motors, got.stop_motors);
      fail_count++;
    end
  endfunction

  // idle length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // value scattered around a threshold, clamped to the field range
  function automatic int around(int center, int spread, int lo, int hi);
    int v;
    v = center - spread + int'($urandom_range(2 * spread));
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // signed angle biased toward the tilt limit
  function automatic int tilt_angle(int lim);
    int v, pick;
    pick = $urandom_range(99);
    if (pick < 88) v = $urandom_range(lim);
    else if (pick < 96) v = around(lim, 2, 0, 1800);
    else v = 1800;
    if (v > 1800) v = 1800;
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic fsup_pkg::item_t mk_tick(bit link, bit button, bit hb, int range_cm,
                                              bit tv, int deg, int pch, int rll);
    fsup_pkg::item_t t;
    t.link_up            = link;
    t.button_pressed     = button;
    t.heartbeat          = hb;
    t.distance_cm        = fsup_pkg::DIST_W'(range_cm);
    t.temp_valid         = tv;
    t.temperature_tenths = fsup_pkg::TEMP_W'(deg);
    t.pitch_tenths       = fsup_pkg::ANGLE_W'(pch);
    t.roll_tenths        = fsup_pkg::ANGLE_W'(rll);
    return t;
  endfunction

  // random tick with heartbeat droughts and obstacle runs
  function automatic fsup_pkg::item_t random_tick();
    int range_cm, deg, pick, t_warn, t_flt;
    t_warn = int'($signed(thr.temp_warn_tenths));
    t_flt  = int'($signed(thr.temp_fault_tenths));

    if (hb_drought > 0) begin
      hb_drought--;
      pick = 0;
    end else begin
      pick = ($urandom_range(99) < 85) ? 1 : 0;
      if ($urandom_range(99) < 3) hb_drought = $urandom_range(60, 5);
    end

    if (obs_run > 0) begin
      range_cm = $urandom_range(int'(thr.obstacle_fault_cm));
      obs_run--;
    end else begin
      range_cm = $urandom_range(99);
      if (range_cm < 4) obs_run = $urandom_range(40, 5);
      if (range_cm < 30) range_cm = around(int'(thr.obstacle_fault_cm), 2, 0, 255);
      else if (range_cm < 50) range_cm = around(int'(thr.obstacle_warn_cm), 2, 0, 255);
      else if (range_cm < 94) range_cm = $urandom_range(200);
      else range_cm = $urandom_range(255, 201);
    end

    deg = $urandom_range(99);
    if (deg < 25) deg = around(t_warn, 3, -400, 800);
    else if (deg < 33) deg = around(t_flt, 2, -400, 800);
    else if (deg < 36) deg = $urandom_range(1) ? -400 : 800;
    else deg = -400 + int'($urandom_range((t_warn < -400) ? 0 : t_warn + 400));

    return mk_tick($urandom_range(99) < 70, $urandom_range(99) < 20, pick[0], range_cm,
                   $urandom_range(99) < 90, deg, tilt_angle(int'(thr.tilt_limit_tenths)),
                   tilt_angle(int'(thr.tilt_limit_tenths)));
  endfunction

  task automatic queue_tick(fsup_pkg::item_t t);
    tick_queue.push_back(t);
    ticks_queued++;
  endtask

  // wait until every queued tick went in and every result came back
  task automatic drain();
    do @(negedge clk_i);
    while (ticks_accepted != ticks_queued || status_expected.size() != 0);
  endtask

  task automatic write_threshold(logic [fsup_pkg::CFG_IDX_W-1:0] idx, int value);
    @(negedge clk_i);
    thr_ch.valid <= 1'b1;
    thr_ch.index <= idx;
    thr_ch.data  <= fsup_pkg::CFG_DATA_W'(value);
    do @(posedge clk_i);
    while (!thr_ch.ready);
  endtask

  task automatic set_thresholds(int of, int ow, int tw, int tf, int tl, int hold, int wd);
    drain();
    write_threshold(fsup_pkg::CFG_OBS_FAULT, of);
    write_threshold(fsup_pkg::CFG_OBS_WARN, ow);
    write_threshold(fsup_pkg::CFG_TEMP_WARN, tw);
    write_threshold(fsup_pkg::CFG_TEMP_FLT, tf);
    write_threshold(fsup_pkg::CFG_TILT_LIM, tl);
    write_threshold(fsup_pkg::CFG_OBS_HOLD, hold);
    write_threshold(fsup_pkg::CFG_WATCHDOG, wd);
    @(negedge clk_i);
    thr_ch.valid <= 1'b0;
  endtask

  task automatic random_ticks(int n);
    repeat (n) queue_tick(random_tick());
  endtask

  // tick driver
  always @(negedge clk_i) begin
    fsup_pkg::item_t nxt;
    if (rst_ni && !(tick_ch.valid && !tick_taken)) begin
      if (send_gap > 0) begin
        tick_ch.valid <= 1'b0;
        send_gap--;
      end else if (tick_queue.size() > 0) begin
        nxt = tick_queue.pop_front();
        tick_ch.valid              <= 1'b1;
        tick_ch.link_up            <= nxt.link_up;
        tick_ch.button_pressed     <= nxt.button_pressed;
        tick_ch.heartbeat          <= nxt.heartbeat;
        tick_ch.distance_cm        <= nxt.distance_cm;
        tick_ch.temp_valid         <= nxt.temp_valid;
        tick_ch.temperature_tenths <= nxt.temperature_tenths;
        tick_ch.pitch_tenths       <= nxt.pitch_tenths;
        tick_ch.roll_tenths        <= nxt.roll_tenths;
        if (send_calm > 0) begin
          send_calm--;
        end else begin
          send_gap = pick_gap();
          if ($urandom_range(99) < 2) send_calm = $urandom_range(80, 20);
        end
      end else begin
        tick_ch.valid <= 1'b0;
      end
    end
  end

  // result sink back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      status_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      status_ch.ready <= 1'b1;
      if (sink_calm > 0) begin
        sink_calm--;
      end else begin
        stall_left = ($urandom_range(99) < 30) ? pick_gap() : 0;
        if ($urandom_range(99) < 1) sink_calm = $urandom_range(80, 20);
      end
    end
  end

  // monitor: threshold writes, accepted ticks and result checks
  always @(posedge clk_i) begin
    fsup_pkg::item_t it;
    fsup_pkg::res_t  got;
    if (!rst_ni) begin
      tick_taken <= 1'b0;
    end else begin
      tick_taken <= tick_ch.valid && tick_ch.ready;
      if (thr_ch.valid && thr_ch.ready) apply_threshold(thr_ch.index, thr_ch.data);
      if (tick_ch.valid && tick_ch.ready) begin
        it.link_up            = tick_ch.link_up;
        it.button_pressed     = tick_ch.button_pressed;
        it.heartbeat          = tick_ch.heartbeat;
        it.distance_cm        = tick_ch.distance_cm;
        it.temp_valid         = tick_ch.temp_valid;
        it.temperature_tenths = tick_ch.temperature_tenths;
        it.pitch_tenths       = tick_ch.pitch_tenths;
        it.roll_tenths        = tick_ch.roll_tenths;
        status_expected.push_back(supervise_tick(it));
        ticks_accepted++;
      end
      if (status_ch.valid && status_ch.ready) begin
        got.mode          = status_ch.mode;
        got.fault_active  = status_ch.fault_active;
        got.fault_code    = status_ch.fault_code;
        got.warn_obstacle = status_ch.warn_obstacle;
        got.warn_temp     = status_ch.warn_temp;
        got.alert_raised  = status_ch.alert_raised;
        got.stop_motors   = status_ch.stop_motors;
        if (status_expected.size() == 0) begin
          $error("result transaction with no tick waiting: mode %0d code %0d",
                 got.mode, got.fault_code);
          fail_count++;
        end else begin
          check_status(status_expected.pop_front(), got);
        end
      end
    end
  end

  // hard limit on run time
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // reset, stimulus phases and end of run
  initial begin
    int of;
    clk_i                      = 1'b0;
    rst_ni                     = 1'b0;
    tick_ch.valid              = 1'b0;
    tick_ch.link_up            = 1'b0;
    tick_ch.button_pressed     = 1'b0;
    tick_ch.heartbeat          = 1'b0;
    tick_ch.distance_cm        = '0;
    tick_ch.temp_valid         = 1'b0;
    tick_ch.temperature_tenths = '0;
    tick_ch.pitch_tenths       = '0;
    tick_ch.roll_tenths        = '0;
    status_ch.ready            = 1'b1;
    thr_ch.valid               = 1'b0;
    thr_ch.index               = '0;
    thr_ch.data                = '0;
    tick_taken                 = 1'b0;
    sup_mode                   = MODE_IDLE;
    flt_latched                = 1'b0;
    flt_code                   = fsup_pkg::FAULT_NONE;
    obs_running                = 1'b0;
    obs_age                    = '0;
    hb_age                     = '0;
    thr = '{obstacle_fault_cm: fsup_pkg::RST_OBS_FAULT,
            obstacle_warn_cm: fsup_pkg::RST_OBS_WARN,
            temp_warn_tenths: fsup_pkg::RST_TEMP_WARN,
            temp_fault_tenths: fsup_pkg::RST_TEMP_FLT,
            tilt_limit_tenths: fsup_pkg::RST_TILT_LIM,
            obstacle_hold_ticks: fsup_pkg::RST_OBS_HOLD,
            watchdog_ticks: fsup_pkg::RST_WATCHDOG};
    ticks_queued   = 0;
    ticks_accepted = 0;
    fail_count     = 0;
    send_gap       = 0;
    send_calm      = 0;
    stall_left     = 0;
    sink_calm      = 0;
    hb_drought     = 0;
    obs_run        = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed walk through every mode at the default thresholds
    queue_tick(mk_tick(1'b0, 1'b1, 1'b1, 0, 1'b1, 0, 0, 0));          // no link, stays idle
    queue_tick(mk_tick(1'b1, 1'b0, 1'b1, 200, 1'b1, 0, 0, 0));        // link comes up
    queue_tick(mk_tick(1'b1, 1'b0, 1'b0, 100, 1'b1, 0, 0, 0));
    queue_tick(mk_tick(1'b0, 1'b1, 1'b1, 200, 1'b1, 0, 300, -300));   // manual, tilt at limit
    queue_tick(mk_tick(1'b0, 1'b0, 1'b1, 255, 1'b1, -400, -300, 300)); // distance beyond range
    queue_tick(mk_tick(1'b1, 1'b1, 1'b1, 16, 1'b1, 351, 0, 0));       // both warnings
    queue_tick(mk_tick(1'b0, 1'b0, 1'b1, 29, 1'b1, 399, 0, 0));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b1, 30, 1'b1, 350, 0, 0));       // warning band edges
    queue_tick(mk_tick(1'b0, 1'b0, 1'b1, 15, 1'b1, 0, 0, 0));         // obstacle timer starts
    queue_tick(mk_tick(1'b0, 1'b0, 1'b1, 0, 1'b0, 800, 1800, 1800));  // failed temp read
    queue_tick(mk_tick(1'b0, 1'b0, 1'b1, 0, 1'b1, 0, 0, 0));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b1, 40, 1'b1, 400, 301, 0));     // tilt then overtemp
    queue_tick(mk_tick(1'b0, 1'b0, 1'b1, 40, 1'b1, 0, 0, 0));         // manual to fault
    queue_tick(mk_tick(1'b1, 1'b0, 1'b0, 40, 1'b1, 0, 0, 0));
    queue_tick(mk_tick(1'b0, 1'b1, 1'b1, 40, 1'b1, 0, 0, 0));         // fault to reset required
    queue_tick(mk_tick(1'b1, 1'b0, 1'b1, 40, 1'b1, 0, 0, 0));
    queue_tick(mk_tick(1'b0, 1'b1, 1'b1, 40, 1'b1, 0, 0, 0));         // back to idle
    queue_tick(mk_tick(1'b1, 1'b0, 1'b1, 100, 1'b1, 0, 0, 0));
    queue_tick(mk_tick(1'b0, 1'b1, 1'b1, 100, 1'b1, -400, -1800, -301)); // tilt fault
    queue_tick(mk_tick(1'b0, 1'b0, 1'b1, 100, 1'b1, 800, 0, 1800));
    queue_tick(mk_tick(1'b0, 1'b1, 1'b1, 100, 1'b1, 0, 0, 0));
    queue_tick(mk_tick(1'b0, 1'b1, 1'b1, 100, 1'b1, 0, 0, 0));
    queue_tick(mk_tick(1'b0, 1'b0, 1'b0, 100, 1'b1, 0, 0, 0));

    random_ticks(250);
    set_thresholds(0, 0, -400, -400, 0, 0, 0);
    random_ticks(200);
    set_thresholds(200, 200, 800, 800, 1800, 65535, 65535);
    random_ticks(200);
    repeat (5) begin
      of = $urandom_range(60);
      set_thresholds(of, of + int'($urandom_range(60)), int'($urandom_range(900)) - 400,
                     int'($urandom_range(1200)) - 400, $urandom_range(1800, 100),
                     $urandom_range(25), $urandom_range(40));
      random_ticks(220);
    end

    drain();
    repeat (5) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/fsup_pkg.sv
sv/fsup_if.sv
sv/fsup_cfg_regs.sv
sv/fsup_supervisor.sv
sv/fault_supervisor_fsm_top.sv
tb/fault_supervisor_fsm_top_tb.sv
